/* src/binary_upload_receiver_unit_macros.svh */
// assertion macros shared by the upload receiver modules
`ifndef BINARY_UPLOAD_RECEIVER_UNIT_MACROS_SVH
`define BINARY_UPLOAD_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BUR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define BUR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bur_pkg.sv */
// shared types and constants of the upload receiver
`timescale 1ns / 1ps

package bur_pkg;

    localparam logic [31:0] CMD_A = 32'h4241_524D;
    localparam logic [31:0] CMD_B = 32'h4250_5043;

    localparam logic [31:0] RST_BASE_A       = 32'h0000_0000;
    localparam logic [31:0] RST_BASE_B       = 32'h1010_0000;
    localparam logic [31:0] RST_LENGTH_LIMIT = 32'd20971520;
    localparam logic [31:0] RST_TIMEOUT      = 32'd5000;
    localparam logic [31:0] LENGTH_BYTES     = 32'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CFG_LINK_ENABLE   = 3'd0,
        CFG_BASE_A        = 3'd1,
        CFG_BASE_B        = 3'd2,
        CFG_LENGTH_LIMIT  = 3'd3,
        CFG_TIMEOUT_TICKS = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_BEGIN   = 3'd0,
        EV_WRITE   = 3'd1,
        EV_DONE    = 3'd2,
        EV_LONG    = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef struct packed {
        logic        link_enable;
        logic [31:0] base_a;
        logic [31:0] base_b;
        logic [31:0] length_limit;
        logic [31:0] timeout_ticks;
    } t_cfg;

    // one queue entry: the results of one item, a second result is always done
    typedef struct packed {
        logic        two;
        t_event      ev0;
        logic        target;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [31:0] len;
    } t_entry;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_status;

endpackage

/* src/bur_front.sv */
// front end: command match, length collection, payload tracking and timeout
`timescale 1ns / 1ps
`include "binary_upload_receiver_unit_macros.svh"

module bur_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bur_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic            i_kind,
    input  logic [7:0]      i_rx_byte,
    output logic            o_push,
    output bur_pkg::t_entry o_entry
);
    import bur_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic        r_target, n_target;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_elapsed, n_elapsed;
    logic        r_timer_running, n_timer_running;

    logic [31:0] shift_next;
    logic [31:0] len_next;
    logic [31:0] tick_next;

    assign shift_next = {r_shift[23:0], i_rx_byte};
    assign len_next   = {r_len[23:0], i_rx_byte};
    assign tick_next  = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;

    always_comb begin
        n_phase         = r_phase;
        n_shift         = r_shift;
        n_target        = r_target;
        n_len           = r_len;
        n_rem           = r_rem;
        n_addr          = r_addr;
        n_elapsed       = r_elapsed;
        n_timer_running = r_timer_running;
        o_push          = 1'b0;
        o_entry         = '0;
        o_entry.target  = r_target;

        if (i_accept && i_cfg.link_enable) begin
            if (i_kind) begin
                if (r_timer_running) begin
                    n_elapsed = tick_next;
                    if (tick_next > i_cfg.timeout_ticks) begin
                        o_push          = 1'b1;
                        o_entry.ev0     = EV_TIMEOUT;
                        n_phase         = PH_IDLE;
                        n_shift         = '0;
                        n_elapsed       = '0;
                        n_timer_running = 1'b0;
                    end
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_shift = shift_next;
                        if (shift_next == CMD_A || shift_next == CMD_B) begin
                            n_phase         = PH_LEN;
                            n_target        = (shift_next == CMD_B);
                            n_addr          = (shift_next == CMD_B) ? i_cfg.base_b
                                                                    : i_cfg.base_a;
                            n_len           = '0;
                            n_rem           = LENGTH_BYTES;
                            n_elapsed       = '0;
                            n_timer_running = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        n_len = len_next;
                        n_rem = r_rem - 32'd1;
                        if (r_rem == 32'd1) begin
                            o_push      = 1'b1;
                            o_entry.len = len_next;
                            if (len_next > i_cfg.length_limit) begin
                                o_entry.ev0     = EV_LONG;
                                n_phase         = PH_IDLE;
                                n_shift         = '0;
                                n_elapsed       = '0;
                                n_timer_running = 1'b0;
                            end else begin
                                o_entry.ev0 = EV_BEGIN;
                                if (len_next == '0) begin
                                    // empty payload finishes right away
                                    o_entry.two     = 1'b1;
                                    n_phase         = PH_IDLE;
                                    n_shift         = '0;
                                    n_elapsed       = '0;
                                    n_timer_running = 1'b0;
                                end else begin
                                    n_phase = PH_DATA;
                                    n_rem   = len_next;
                                end
                            end
                        end
                    end
                    PH_DATA: begin
                        o_push       = 1'b1;
                        o_entry.ev0  = EV_WRITE;
                        o_entry.addr = r_addr;
                        o_entry.data = i_rx_byte;
                        o_entry.len  = r_len;
                        n_addr       = r_addr + 32'd1;
                        n_rem        = r_rem - 32'd1;
                        if (r_rem == 32'd1) begin
                            o_entry.two     = 1'b1;
                            n_phase         = PH_IDLE;
                            n_shift         = '0;
                            n_elapsed       = '0;
                            n_timer_running = 1'b0;
                        end
                    end
                    default: begin
                        n_phase         = PH_IDLE;
                        n_shift         = '0;
                        n_elapsed       = '0;
                        n_timer_running = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_shift         <= '0;
            r_target        <= 1'b0;
            r_len           <= '0;
            r_rem           <= '0;
            r_addr          <= '0;
            r_elapsed       <= '0;
            r_timer_running <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_shift         <= n_shift;
            r_target        <= n_target;
            r_len           <= n_len;
            r_rem           <= n_rem;
            r_addr          <= n_addr;
            r_elapsed       <= n_elapsed;
            r_timer_running <= n_timer_running;
        end
    end

    `BUR_ASSERT_NOW(a_timer_tracks_phase, i_clk, i_rst_n, 1'b1,
        r_timer_running == (r_phase != PH_IDLE), "timer state disagrees with phase")
    `BUR_ASSERT_NOW(a_len_count_range, i_clk, i_rst_n, r_phase == PH_LEN,
        (r_rem != '0) && (r_rem <= LENGTH_BYTES), "length byte count out of range")

endmodule

/* src/bur_queue.sv */
// small ring buffer between front and back
`timescale 1ns / 1ps
`include "binary_upload_receiver_unit_macros.svh"

module bur_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bur_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output bur_pkg::t_entry    o_head,
    output bur_pkg::t_q_status o_status
);
    import bur_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.head_valid = (r_count != '0);
    assign o_head              = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `BUR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= QUEUE_CW'(QUEUE_DEPTH), "queue count beyond depth")
    `BUR_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, do_push && !do_pop,
        r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

/* src/bur_back.sv */
// back end: unpacks queue entries into result items on the output register
`timescale 1ns / 1ps
`include "binary_upload_receiver_unit_macros.svh"

module bur_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bur_pkg::t_entry    i_head,
    input  bur_pkg::t_q_status i_status,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [2:0]         o_event,
    output logic               o_target,
    output logic [31:0]        o_addr,
    output logic [7:0]         o_data,
    output logic [31:0]        o_len,
    output logic               o_last
);
    import bur_pkg::*;

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    t_event      r_event;
    logic        r_target;
    logic [31:0] r_addr;
    logic [7:0]  r_data;
    logic [31:0] r_len;
    logic        r_last;
    logic        load;

    assign load  = i_status.head_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_sub || !i_head.two);

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = !r_sub && i_head.two;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_target <= i_head.target;
            if (r_sub) begin
                // trailing done of a two-result item
                r_event <= EV_DONE;
                r_addr  <= '0;
                r_data  <= '0;
                r_len   <= i_head.len;
                r_last  <= 1'b1;
            end else begin
                r_event <= i_head.ev0;
                r_addr  <= i_head.addr;
                r_data  <= i_head.data;
                r_len   <= (i_head.ev0 == EV_WRITE || i_head.ev0 == EV_TIMEOUT) ? '0
                                                                              : i_head.len;
                r_last  <= !i_head.two;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_event  = r_event;
    assign o_target = r_target;
    assign o_addr   = r_addr;
    assign o_data   = r_data;
    assign o_len    = r_len;
    assign o_last   = r_last;

    `BUR_ASSERT_NOW(a_second_half_pending, i_clk, i_rst_n, r_sub,
        i_status.head_valid && i_head.two, "second result without a two-result head")

endmodule

/* src/binary_upload_receiver_unit.sv */
// top level of the binary upload receiver
`timescale 1ns / 1ps
// binary upload receiver
// input channel (s_axis_*): one item per handshake, either a received link byte
// or one time tick. while idle the bytes shift into a command word; a match on
// either upload command selects target a or b and arms the timeout. four
// big-endian length bytes follow, then the payload bytes.
// output channel (m_axis_*): begin, one write per payload byte with its address,
// done, or an abort (too long, timeout). tlast marks the final result of an item.
// configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
// results: an accepted item's results are written into the queue, then loaded from
// the queue head into the output register. intake: one item per cycle while the
// queue is not full; the final payload byte and a zero length each yield two
// results, which the back end sends one after the other while the front end keeps
// taking items into the four-entry queue.
// stall: when m_axis_tready is low the queue fills and s_axis_tready drops once
// all four entries are held; nothing is lost.
// reset (synchronous, i_rst_n low): block idle, queue and output empty,
// registers back to their defaults.

module binary_upload_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] kind (1 = tick)
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] write_address, [39:32] write_data,
                                        // [71:40] payload_length
    output logic [3:0]  m_axis_tuser,   // [2:0] event_res, [3] target
    output logic        m_axis_tlast    // last
);
    import bur_pkg::*;

    t_cfg      r_cfg;
    t_entry    front_entry;
    t_entry    q_head;
    t_q_status q_status;
    logic      front_push;
    logic      back_pop;
    logic      s_accept;

    logic [2:0]  back_event;
    logic        back_target;
    logic [31:0] back_addr;
    logic [7:0]  back_data;
    logic [31:0] back_len;

    // configuration registers, sampled by the front end when it needs them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_enable   <= 1'b1;
            r_cfg.base_a        <= RST_BASE_A;
            r_cfg.base_b        <= RST_BASE_B;
            r_cfg.length_limit  <= RST_LENGTH_LIMIT;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LINK_ENABLE:   r_cfg.link_enable   <= i_cfg_data[0];
                CFG_BASE_A:        r_cfg.base_a        <= i_cfg_data;
                CFG_BASE_B:        r_cfg.base_b        <= i_cfg_data;
                CFG_LENGTH_LIMIT:  r_cfg.length_limit  <= i_cfg_data;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end takes an item whenever the queue has room for its results
    assign s_axis_tready = !q_status.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    bur_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (s_accept),
        .i_kind    (s_axis_tuser[0]),
        .i_rx_byte (s_axis_tdata),
        .o_push    (front_push),
        .o_entry   (front_entry)
    );

    // decouples item intake from result delivery
    bur_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_entry  (front_entry),
        .i_pop    (back_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    bur_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_status (q_status),
        .o_pop    (back_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_event  (back_event),
        .o_target (back_target),
        .o_addr   (back_addr),
        .o_data   (back_data),
        .o_len    (back_len),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {back_len, back_data, back_addr};
    assign m_axis_tuser = {back_target, back_event};

endmodule
